// ===== src/mts_pkg.sv =====
// shared types, constants and note tables of the melody tone sequencer
package mts_pkg;

    localparam int MAX_NOTES   = 8;
    localparam int POS_W       = $clog2(MAX_NOTES);
    localparam int CMD_W       = 2;
    localparam int MEL_W       = 2;
    localparam int PERIOD_W    = 16;
    localparam int LENGTH_W    = 16;
    localparam int ALARM_W     = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_TICK       = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START      = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ALARM_TICK = 2'd2;

    localparam logic [MEL_W-1:0] MEL_WELCOME = 2'd0;
    localparam logic [MEL_W-1:0] MEL_WRONG   = 2'd1;
    localparam logic [MEL_W-1:0] MEL_CLICK   = 2'd2;
    localparam logic [MEL_W-1:0] MEL_ALARM   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_RESTART = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_LENGTH  = 2'd2;

    localparam logic [ALARM_W-1:0]  ALARM_RESTART_RST = 32'd10000;
    localparam logic [PERIOD_W-1:0] CLICK_PERIOD_RST  = 16'd1000;
    localparam logic [LENGTH_W-1:0] CLICK_LENGTH_RST  = 16'd100;

    // tone periods in microseconds
    localparam logic [PERIOD_W-1:0] TONE_B5  = 16'd1910;
    localparam logic [PERIOD_W-1:0] TONE_HI  = 16'd1430;
    localparam logic [PERIOD_W-1:0] TONE_TOP = 16'd1275;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [MEL_W-1:0] melody_sel;
    } cmd_item_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] tone_period_us;
        logic                tone_on;
        logic                playing;
        logic [POS_W-1:0]    note_index;
        logic                melody_done;
    } tone_item_t;

    typedef struct packed {
        logic [ALARM_W-1:0]  alarm_restart_ms;
        logic [PERIOD_W-1:0] click_period_us;
        logic [LENGTH_W-1:0] click_length_ms;
    } cfg_t;

    // fixed tone table, zero beyond the last note of a melody
    function automatic logic [PERIOD_W-1:0] tone_rom(input logic [MEL_W-1:0] mel,
                                                     input logic [POS_W-1:0] pos);
        logic [PERIOD_W-1:0] val;
        val = '0;
        unique case (mel)
            MEL_WELCOME:
            begin
                if (pos == POS_W'(0)) val = TONE_B5;
                else if (pos == POS_W'(1)) val = TONE_HI;
                else if (pos == POS_W'(2)) val = TONE_TOP;
            end
            MEL_WRONG, MEL_ALARM:
            begin
                if (pos < POS_W'(6)) val = pos[0] ? TONE_HI : TONE_TOP;
            end
            default:
            begin
                val = '0;
            end
        endcase
        return val;
    endfunction

    // fixed note length table in milliseconds
    function automatic logic [LENGTH_W-1:0] len_rom(input logic [MEL_W-1:0] mel,
                                                    input logic [POS_W-1:0] pos);
        logic [LENGTH_W-1:0] val;
        val = '0;
        unique case (mel)
            MEL_WELCOME:
            begin
                if (pos == POS_W'(0)) val = 16'd200;
                else if (pos == POS_W'(1)) val = 16'd250;
                else if (pos == POS_W'(2)) val = 16'd400;
            end
            MEL_WRONG:
            begin
                if (pos < POS_W'(6)) val = 16'd250;
            end
            MEL_ALARM:
            begin
                if (pos < POS_W'(5)) val = 16'd250;
                else if (pos == POS_W'(5)) val = 16'd2000;
            end
            default:
            begin
                val = '0;
            end
        endcase
        return val;
    endfunction

    function automatic logic [POS_W:0] count_rom(input logic [MEL_W-1:0] mel);
        logic [POS_W:0] val;
        unique case (mel)
            MEL_WELCOME: val = (POS_W+1)'(3);
            MEL_WRONG:   val = (POS_W+1)'(6);
            MEL_CLICK:   val = (POS_W+1)'(1);
            default:     val = (POS_W+1)'(6);
        endcase
        return val;
    endfunction

endpackage

// ===== src/mts_cmd_if.sv =====
// command channel: tick and start transactions
interface mts_cmd_if;
    import mts_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] cmd;
    logic [MEL_W-1:0] melody_sel;

    modport source (output valid, output cmd, output melody_sel, input ready);
    modport sink   (input valid, input cmd, input melody_sel, output ready);
endinterface

// ===== src/mts_tone_if.sv =====
// result channel: tone state transactions
interface mts_tone_if;
    import mts_pkg::*;

    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] tone_period_us;
    logic                tone_on;
    logic                playing;
    logic [POS_W-1:0]    note_index;
    logic                melody_done;

    modport source (output valid, output tone_period_us, output tone_on, output playing,
                    output note_index, output melody_done, input ready);
    modport sink   (input valid, input tone_period_us, input tone_on, input playing,
                    input note_index, input melody_done, output ready);
endinterface

// ===== src/melody_tone_sequencer_unit.sv =====
// top level of the melody tone sequencer
// Buzzer melody sequencer: each command transaction (1 ms tick, melody start, or tick with
// alarm restart check) yields exactly one tone transaction giving the tone period, drive
// enable, playing flag, note index and end-of-melody flag. One transaction is taken every
// clock cycle while the tone channel does not stall; a command passes through the input
// register and then the result register, with all note timing done combinationally
// between them. A stalled tone channel holds the result register and, once the input
// register is also full, back-pressures the command channel. Configuration writes take
// effect on the next cycle and are expected only while no transaction is in flight.
module melody_tone_sequencer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    mts_cmd_if.sink                        cmd_chan,
    mts_tone_if.source                     tone_chan,
    input  logic                           cfg_wr_en,
    input  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0] cfg_wr_data
);
    import mts_pkg::*;

    cfg_t       cfg;
    logic       item_valid;
    cmd_item_t  item;
    logic       take;
    logic       out_free;
    tone_item_t result;

    mts_cfg_regs u_cfg_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    mts_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_chan   (cmd_chan),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mts_seq_core u_seq_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .cfg        (cfg),
        .take       (take),
        .result     (result)
    );

    mts_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take),
        .result    (result),
        .out_free  (out_free),
        .tone_chan (tone_chan)
    );
endmodule

// ===== src/mts_cfg_regs.sv =====
// configuration registers with plain write port
module mts_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mts_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mts_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output mts_pkg::cfg_t                  cfg
);
    import mts_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_ALARM_RESTART: cfg_next.alarm_restart_ms = cfg_wr_data[ALARM_W-1:0];
                CFG_CLICK_PERIOD:  cfg_next.click_period_us  = cfg_wr_data[PERIOD_W-1:0];
                CFG_CLICK_LENGTH:  cfg_next.click_length_ms  = cfg_wr_data[LENGTH_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_restart_ms <= ALARM_RESTART_RST;
            cfg_reg.click_period_us  <= CLICK_PERIOD_RST;
            cfg_reg.click_length_ms  <= CLICK_LENGTH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;
endmodule

// ===== src/mts_in_stage.sv =====
// input register for command transactions
module mts_in_stage (
    input  logic               clk,
    input  logic               rst_n,
    mts_cmd_if.sink            cmd_chan,
    input  logic               take,
    output logic               item_valid,
    output mts_pkg::cmd_item_t item
);
    import mts_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    cmd_item_t item_reg;
    logic      load;

    assign cmd_chan.ready = !valid_reg || take;
    assign load           = cmd_chan.valid && cmd_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.cmd        <= cmd_chan.cmd;
            item_reg.melody_sel <= cmd_chan.melody_sel;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;
endmodule

// ===== src/mts_seq_core.sv =====
// sequencer state and per-transaction note timing
module mts_seq_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  mts_pkg::cmd_item_t  item,
    input  logic                out_free,
    input  mts_pkg::cfg_t       cfg,
    output logic                take,
    output mts_pkg::tone_item_t result
);
    import mts_pkg::*;

    logic                active_reg,  active_next;
    logic [MEL_W-1:0]    mel_reg,     mel_next;
    logic [POS_W-1:0]    pos_reg,     pos_next;
    logic [LENGTH_W-1:0] elapsed_reg, elapsed_next;
    logic [ALARM_W-1:0]  alarm_reg,   alarm_next;
    logic [PERIOD_W-1:0] period_reg,  period_next;

    logic                is_start;
    logic [ALARM_W-1:0]  alarm_inc;
    logic                restart;
    logic                do_start;
    logic [MEL_W-1:0]    start_mel;
    logic [PERIOD_W-1:0] start_period;
    logic                s_active;
    logic [MEL_W-1:0]    s_mel;
    logic [POS_W-1:0]    s_pos;
    logic [LENGTH_W-1:0] s_elapsed;
    logic [PERIOD_W-1:0] s_period;
    logic [LENGTH_W-1:0] el_inc;
    logic [LENGTH_W-1:0] note_len;
    logic [POS_W:0]      pos_plus;
    logic [POS_W-1:0]    pos_adv;
    logic [PERIOD_W-1:0] adv_period;
    logic                done;

    assign take = item_valid && out_free;

    always_comb
    begin
        is_start  = (item.cmd == CMD_START);
        alarm_inc = (alarm_reg != '1) ? alarm_reg + ALARM_W'(1) : alarm_reg;
        restart   = (item.cmd == CMD_ALARM_TICK) && (alarm_inc >= cfg.alarm_restart_ms);
        do_start  = is_start || restart;
        start_mel = is_start ? item.melody_sel : MEL_ALARM;

        start_period = (start_mel == MEL_CLICK) ? cfg.click_period_us
                                                : tone_rom(start_mel, '0);

        if (is_start)
            alarm_next = (item.melody_sel == MEL_ALARM) ? '0 : alarm_reg;
        else
            alarm_next = restart ? '0 : alarm_inc;

        // state after an optional melody start
        s_active  = do_start ? 1'b1         : active_reg;
        s_mel     = do_start ? start_mel    : mel_reg;
        s_pos     = do_start ? '0           : pos_reg;
        s_elapsed = do_start ? '0           : elapsed_reg;
        s_period  = do_start ? start_period : period_reg;

        // note timing on ticks
        el_inc     = (s_elapsed != '1) ? s_elapsed + LENGTH_W'(1) : s_elapsed;
        note_len   = (s_mel == MEL_CLICK) ? cfg.click_length_ms : len_rom(s_mel, s_pos);
        pos_plus   = {1'b0, s_pos} + (POS_W+1)'(1);
        pos_adv    = pos_plus[POS_W-1:0];
        adv_period = (s_mel == MEL_CLICK) ? cfg.click_period_us : tone_rom(s_mel, pos_adv);

        active_next  = s_active;
        mel_next     = s_mel;
        pos_next     = s_pos;
        elapsed_next = s_elapsed;
        period_next  = s_period;
        done         = 1'b0;

        if (!is_start && s_active)
        begin
            if (el_inc >= note_len)
            begin
                elapsed_next = '0;
                if (pos_plus >= count_rom(s_mel))
                begin
                    active_next = 1'b0;
                    done        = 1'b1;
                end
                else
                begin
                    pos_next    = pos_adv;
                    period_next = adv_period;
                end
            end
            else
            begin
                elapsed_next = el_inc;
            end
        end

        result.tone_period_us = period_next;
        result.tone_on        = active_next;
        result.playing        = active_next;
        result.note_index     = pos_next;
        result.melody_done    = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            mel_reg     <= '0;
            pos_reg     <= '0;
            elapsed_reg <= '0;
            alarm_reg   <= '0;
            period_reg  <= '0;
        end
        else if (take)
        begin
            active_reg  <= active_next;
            mel_reg     <= mel_next;
            pos_reg     <= pos_next;
            elapsed_reg <= elapsed_next;
            alarm_reg   <= alarm_next;
            period_reg  <= period_next;
        end
    end
endmodule

// ===== src/mts_out_stage.sv =====
// result register driving the tone channel
module mts_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  mts_pkg::tone_item_t result,
    output logic                out_free,
    mts_tone_if.source          tone_chan
);
    import mts_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    tone_item_t data_reg;

    assign out_free = !valid_reg || tone_chan.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (tone_chan.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result;
    end

    assign tone_chan.valid          = valid_reg;
    assign tone_chan.tone_period_us = data_reg.tone_period_us;
    assign tone_chan.tone_on        = data_reg.tone_on;
    assign tone_chan.playing        = data_reg.playing;
    assign tone_chan.note_index     = data_reg.note_index;
    assign tone_chan.melody_done    = data_reg.melody_done;
endmodule
